### design/fsr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
// No dependencies; every other file of the block uses it through scoped names.
`timescale 1ns / 1ps

package fsr_pkg;

	// Bytes held by the pattern registers
	localparam int REG_BYTES = 16;
	// Width of a length field or a command byte count
	localparam int LEN_W = 5;
	// Width of the configuration register index
	localparam int IDX_W = 3;

	typedef logic [7:0] byte_t;

	// Configuration register map
	typedef enum logic [IDX_W-1:0] {
		REG_SEARCH_LOW     = 3'd0,
		REG_SEARCH_HIGH    = 3'd1,
		REG_SEARCH_LENGTH  = 3'd2,
		REG_REPLACE_LOW    = 3'd3,
		REG_REPLACE_HIGH   = 3'd4,
		REG_REPLACE_LENGTH = 3'd5
	} cfg_reg_t;

	// Pattern settings as seen by the front end, lengths already capped
	typedef struct packed {
		logic [REG_BYTES-1:0][7:0] search;
		logic [LEN_W-1:0]          slen;
		logic [REG_BYTES-1:0][7:0] repl;
		logic [LEN_W-1:0]          rlen;
	} fsr_cfg_t;

	// One emit command: cnt bytes from the bottom of the list, last marks end of text.
	// A command with cnt of zero always has last set and yields one empty result.
	typedef struct packed {
		logic [REG_BYTES-1:0][7:0] bytes;
		logic [LEN_W-1:0]          cnt;
		logic                      last;
	} cmd_t;

endpackage

### design/fsr_front.sv
// Front end: accepts text items, keeps the match window and issues emit commands.
// Depends on fsr_pkg.
`timescale 1ns / 1ps

module fsr_front #(
	parameter int WIN = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fsr_pkg::fsr_cfg_t cfg,
	input  logic              clr,
	input  logic              acc,
	input  logic [7:0]        in_byte,
	input  logic              byte_present,
	input  logic              text_end,
	output logic              cmd_push,
	output fsr_pkg::cmd_t     cmd
);

	localparam int CNT_W = $clog2(WIN + 1);
	localparam int LW    = fsr_pkg::LEN_W;

	logic [WIN-1:0][7:0] win_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [WIN-1:0][7:0] win_ins;
	logic [WIN-1:0][7:0] win_d;
	logic [CNT_W-1:0]    cnt_d;
	logic [LW-1:0]       cnt_ext;
	logic [LW-1:0]       cnt_inc;
	logic                hit;
	logic                win_full;

	assign cnt_ext  = LW'(cnt_q);
	assign cnt_inc  = cnt_ext + LW'(1);
	assign win_full = (cnt_inc == cfg.slen);

	// Place the incoming byte at the fill position and compare against the pattern
	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < WIN; i++) begin
			win_ins[i] = (LW'(i) == cnt_ext) ? in_byte : win_q[i];
			if ((LW'(i) < cfg.slen) && (win_ins[i] != cfg.search[i])) begin
				hit = 1'b0;
			end
		end
	end

	// Classify the item and build its command
	always_comb begin
		win_d     = win_q;
		cnt_d     = cnt_q;
		cmd.bytes = '0;
		cmd.cnt   = '0;
		cmd.last  = text_end;
		if (byte_present) begin
			if (cfg.slen == '0) begin
				// pass through
				cmd.bytes[0] = in_byte;
				cmd.cnt      = LW'(1);
			end else begin
				win_d = win_ins;
				cnt_d = CNT_W'(cnt_inc);
				if (win_full && hit) begin
					cmd.bytes = cfg.repl;
					cmd.cnt   = cfg.rlen;
					cnt_d     = '0;
				end else if (win_full) begin
					if (text_end) begin
						for (int i = 0; i < WIN; i++) begin
							cmd.bytes[i] = win_ins[i];
						end
						cmd.cnt = cfg.slen;
					end else begin
						cmd.bytes[0] = win_ins[0];
						cmd.cnt      = LW'(1);
					end
					// drop the oldest byte
					for (int i = 0; i < WIN - 1; i++) begin
						win_d[i] = win_ins[i+1];
					end
					cnt_d = CNT_W'(cfg.slen - LW'(1));
				end else if (text_end) begin
					for (int i = 0; i < WIN; i++) begin
						cmd.bytes[i] = win_ins[i];
					end
					cmd.cnt = cnt_inc;
				end
			end
		end else if (text_end) begin
			for (int i = 0; i < WIN; i++) begin
				cmd.bytes[i] = win_q[i];
			end
			cmd.cnt = cnt_ext;
		end
		if (text_end) begin
			cnt_d = '0;
		end
	end

	assign cmd_push = acc && (text_end || (cmd.cnt != '0));

	// Window fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clr) begin
			cnt_q <= '0;
		end else if (acc) begin
			cnt_q <= cnt_d;
		end
	end

	// Window bytes, valid below the fill count
	always_ff @(posedge clk) begin
		if (acc) begin
			win_q <= win_d;
		end
	end

	a_cnt_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.slen != '0) |-> (cnt_ext < cfg.slen))
		else $error("window count reached search length");

	a_cmd_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (cmd.cnt <= LW'(WIN)))
		else $error("command longer than window");

endmodule

### design/fsr_cmd_queue.sv
// Two-entry command queue between the front end and the emitter.
// Depends on fsr_pkg.
`timescale 1ns / 1ps

module fsr_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  fsr_pkg::cmd_t wdata,
	output logic          full,
	input  logic          rd,
	output fsr_pkg::cmd_t rdata,
	output logic          not_empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	fsr_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Store commands
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> (!full || rd))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> not_empty)
		else $error("command queue underflow");

endmodule

### design/fsr_back.sv
// Emitter: expands queued commands into one result per cycle while pop is held.
// Depends on fsr_pkg.
`timescale 1ns / 1ps

module fsr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  fsr_pkg::cmd_t q_data,
	input  logic          q_not_empty,
	output logic          q_rd,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    out_byte,
	output logic          out_valid,
	output logic          out_last
);

	localparam int LW = fsr_pkg::LEN_W;

	fsr_pkg::cmd_t cur_q;
	logic          cur_vld_q;
	logic          advance;
	logic          done;

	assign advance = pop && cur_vld_q;
	assign done    = advance && (cur_q.cnt <= LW'(1));
	assign q_rd    = (!cur_vld_q || done) && q_not_empty;

	assign empty     = !cur_vld_q;
	assign out_valid = (cur_q.cnt != '0);
	assign out_byte  = out_valid ? cur_q.bytes[0] : 8'd0;
	assign out_last  = cur_q.last && (cur_q.cnt <= LW'(1));

	// Occupancy of the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
		end else if (q_rd) begin
			cur_vld_q <= 1'b1;
		end else if (done) begin
			cur_vld_q <= 1'b0;
		end
	end

	// Load a new command or shift out the delivered byte
	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_data;
		end else if (advance && !done) begin
			cur_q.bytes <= cur_q.bytes >> 8;
			cur_q.cnt   <= cur_q.cnt - LW'(1);
		end
	end

	a_empty_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_vld_q && (cur_q.cnt == '0)) |-> cur_q.last)
		else $error("empty result without end mark");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && out_last && !q_not_empty) |=> empty)
		else $error("result shown after end of text");

endmodule

### design/stream_find_replace_core.sv
// Top level of the stream find-and-replace block: configuration registers,
// front end, command queue and emitter. Depends on fsr_pkg and the fsr_* modules.
`timescale 1ns / 1ps

// Text enters one byte per cycle through push/full, and each leftmost,
// non-overlapping occurrence of the search string is replaced on the way out.
// The front end classifies an item in the cycle it is accepted and hands at
// most one command to a two-entry queue; the emitter drains commands at one
// result per cycle while pop is held. A result is registered in the queue and
// in the emitter before it appears. An item that yields k results (k up to the
// replacement length, or the window length at end of text) holds the emitter
// for k results, so the sustained rate is one item per cycle while each item
// yields at most one result and pop is held; the input stalls through full
// once the queue holds two pending commands. Program the registers only while
// the block is idle; writing the search length drops any pending window bytes.
module stream_find_replace_core #(
	parameter int MAX_PATTERN_BYTES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [fsr_pkg::IDX_W-1:0]       wr_index,
	input  logic [63:0]                     wr_data,
	input  logic [7:0]                      in_byte,
	input  logic                            byte_present,
	input  logic                            text_end,
	input  logic                            push,
	output logic                            full,
	output logic [7:0]                      out_byte,
	output logic                            out_valid,
	output logic                            out_last,
	output logic                            empty,
	input  logic                            pop
);

	localparam int WIN = (MAX_PATTERN_BYTES < fsr_pkg::REG_BYTES) ?
		MAX_PATTERN_BYTES : fsr_pkg::REG_BYTES;
	localparam int LW  = fsr_pkg::LEN_W;

	logic [63:0]   search_low_q;
	logic [63:0]   search_high_q;
	logic [LW-1:0] search_len_q;
	logic [63:0]   repl_low_q;
	logic [63:0]   repl_high_q;
	logic [LW-1:0] repl_len_q;

	fsr_pkg::fsr_cfg_t cfg;
	fsr_pkg::cmd_t     cmd;
	fsr_pkg::cmd_t     q_data;
	logic              clr;
	logic              acc;
	logic              cmd_push;
	logic              q_rd;
	logic              q_not_empty;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_low_q  <= '0;
			search_high_q <= '0;
			search_len_q  <= '0;
			repl_low_q    <= '0;
			repl_high_q   <= '0;
			repl_len_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				fsr_pkg::REG_SEARCH_LOW:     search_low_q  <= wr_data;
				fsr_pkg::REG_SEARCH_HIGH:    search_high_q <= wr_data;
				fsr_pkg::REG_SEARCH_LENGTH:  search_len_q  <= wr_data[LW-1:0];
				fsr_pkg::REG_REPLACE_LOW:    repl_low_q    <= wr_data;
				fsr_pkg::REG_REPLACE_HIGH:   repl_high_q   <= wr_data;
				fsr_pkg::REG_REPLACE_LENGTH: repl_len_q    <= wr_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// Cap lengths to the window size
	assign cfg.search = {search_high_q, search_low_q};
	assign cfg.repl   = {repl_high_q, repl_low_q};
	assign cfg.slen   = (search_len_q > LW'(WIN)) ? LW'(WIN) : search_len_q;
	assign cfg.rlen   = (repl_len_q > LW'(WIN)) ? LW'(WIN) : repl_len_q;

	assign clr = wr_en && (wr_index == fsr_pkg::REG_SEARCH_LENGTH);
	assign acc = push && !full;

	fsr_front #(
		.WIN (WIN)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.clr          (clr),
		.acc          (acc),
		.in_byte      (in_byte),
		.byte_present (byte_present),
		.text_end     (text_end),
		.cmd_push     (cmd_push),
		.cmd          (cmd)
	);

	fsr_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (cmd_push),
		.wdata     (cmd),
		.full      (full),
		.rd        (q_rd),
		.rdata     (q_data),
		.not_empty (q_not_empty)
	);

	fsr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_data      (q_data),
		.q_not_empty (q_not_empty),
		.q_rd        (q_rd),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.out_valid   (out_valid),
		.out_last    (out_last)
	);

endmodule

### verif/stream_find_replace_core_tb.sv
// Self-checking testbench for stream_find_replace_core: queue-style driver and monitor,
// an in-bench find-and-replace predictor and a scoreboard. Depends on fsr_pkg and the RTL.
`timescale 1ns / 1ps

module stream_find_replace_core_tb;

	// One input transaction and one expected output transaction
	typedef struct packed {
		logic [7:0] ch;
		logic       present;
		logic       eot;
	} text_item_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       valid;
		logic       last;
	} out_char_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        wr_en = 1'b0;
	logic [fsr_pkg::IDX_W-1:0]   wr_index = '0;
	logic [63:0]                 wr_data = '0;
	logic [7:0]                  in_byte = '0;
	logic                        byte_present = 1'b0;
	logic                        text_end = 1'b0;
	logic                        push = 1'b0;
	logic                        full;
	logic [7:0]                  out_byte;
	logic                        out_valid;
	logic                        out_last;
	logic                        empty;
	logic                        pop = 1'b0;

	// Shadow of the pattern registers and the match window
	logic [63:0]         srch_lo = '0, srch_hi = '0, repl_lo = '0, repl_hi = '0;
	logic [4:0]          srch_len_reg = '0, repl_len_reg = '0;
	logic [7:0]          window [16];
	int                  win_fill = 0;

	text_item_t          text_q [$];
	out_char_t           out_char_q [$];
	text_item_t          drv_item;
	out_char_t           want;
	logic                took = 1'b0;
	int                  send_idle = 24;
	int                  recv_idle = 67;
	int                  errors = 0;

	stream_find_replace_core #(.MAX_PATTERN_BYTES(16)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_byte(in_byte),
		.byte_present(byte_present),
		.text_end(text_end),
		.push(push),
		.full(full),
		.out_byte(out_byte),
		.out_valid(out_valid),
		.out_last(out_last),
		.empty(empty),
		.pop(pop)
	);

	always #5 clk = ~clk;

	function automatic int capped(logic [4:0] len);
		return (len > 5'd16) ? 16 : int'(len);
	endfunction

	function automatic logic [7:0] pat_char(logic [63:0] lo, logic [63:0] hi, int i);
		return (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
	endfunction

	// Compute the output characters caused by one accepted text transaction
	function automatic void predict_replace(text_item_t it);
		out_char_t res [17];
		int        n;
		int        slen;
		int        rlen;
		int        i;
		bit        hit;
		n = 0;
		slen = capped(srch_len_reg);
		if (it.present) begin
			if (slen == 0) begin
				res[n] = '{ch: it.ch, valid: 1'b1, last: 1'b0};
				n++;
			end else begin
				window[win_fill] = it.ch;
				win_fill++;
				if (win_fill == slen) begin
					hit = 1'b1;
					for (i = 0; i < slen; i++)
						if (window[i] != pat_char(srch_lo, srch_hi, i))
							hit = 1'b0;
					if (hit) begin
						rlen = capped(repl_len_reg);
						for (i = 0; i < rlen; i++) begin
							res[n] = '{ch: pat_char(repl_lo, repl_hi, i), valid: 1'b1, last: 1'b0};
							n++;
						end
						win_fill = 0;
					end else begin
						res[n] = '{ch: window[0], valid: 1'b1, last: 1'b0};
						n++;
						for (i = 0; i < slen - 1; i++)
							window[i] = window[i+1];
						win_fill--;
					end
				end
			end
		end
		// Flush the window at end of text; an empty marker if nothing else is due
		if (it.eot) begin
			for (i = 0; i < win_fill; i++) begin
				res[n] = '{ch: window[i], valid: 1'b1, last: 1'b0};
				n++;
			end
			win_fill = 0;
			if (n == 0) begin
				res[n] = '{ch: 8'h00, valid: 1'b0, last: 1'b0};
				n++;
			end
			res[n-1].last = 1'b1;
		end
		for (i = 0; i < n; i++)
			out_char_q.push_back(res[i]);
	endfunction

	// Drive the next text transaction at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || took) begin
			if (text_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				drv_item = text_q.pop_front();
				push <= 1'b1;
				in_byte <= drv_item.ch;
				byte_present <= drv_item.present;
				text_end <= drv_item.eot;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Predict on every accepted input transaction
	always @(posedge clk) begin
		took <= arst_n && push && !full;
		if (arst_n && push && !full)
			predict_replace('{ch: in_byte, present: byte_present, eot: text_end});
	end

	// Randomly stall the output side
	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	task automatic report(string fld, logic [7:0] exp_val, logic [7:0] act_val);
		errors++;
		$display("%0t: %s expected %h got %h", $time, fld, exp_val, act_val);
	endtask

	// Check each accepted output transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (out_char_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result expected none got byte %h valid %b last %b",
					$time, out_byte, out_valid, out_last);
			end else begin
				want = out_char_q.pop_front();
				if (out_byte !== want.ch)
					report("out_byte", want.ch, out_byte);
				if (out_valid !== want.valid)
					report("out_valid", 8'(want.valid), 8'(out_valid));
				if (out_last !== want.last)
					report("out_last", 8'(want.last), 8'(out_last));
			end
		end
	end

	task automatic add_item(logic [7:0] ch, bit present, bit eot);
		text_q.push_back('{ch: ch, present: present, eot: eot});
	endtask

	task automatic add_text(string s, bit eot_last);
		int i;
		for (i = 0; i < s.len(); i++)
			add_item(s[i], 1'b1, eot_last && (i == s.len() - 1));
	endtask

	// Hold until all input is taken and every result has come, then let the core settle
	task automatic wait_idle();
		while (text_q.size() != 0 || push || out_char_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(fsr_pkg::cfg_reg_t idx, logic [63:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			fsr_pkg::REG_SEARCH_LOW: srch_lo = val;
			fsr_pkg::REG_SEARCH_HIGH: srch_hi = val;
			fsr_pkg::REG_SEARCH_LENGTH: begin
				srch_len_reg = val[4:0];
				win_fill = 0;
			end
			fsr_pkg::REG_REPLACE_LOW: repl_lo = val;
			fsr_pkg::REG_REPLACE_HIGH: repl_hi = val;
			fsr_pkg::REG_REPLACE_LENGTH: repl_len_reg = val[4:0];
			default: ;
		endcase
	endtask

	// Program a search string drawn mostly from a three-byte alphabet, random replacement
	task automatic set_pattern(logic [63:0] slen_data, logic [63:0] rlen_data);
		logic [7:0]  alpha [3];
		logic [63:0] lo, hi;
		int          i;
		for (i = 0; i < 3; i++)
			alpha[i] = 8'($urandom);
		for (i = 0; i < 16; i++) begin
			if (i < 8)
				lo[8*i +: 8] = ($urandom_range(9) < 7) ? alpha[$urandom_range(2)] : 8'($urandom);
			else
				hi[8*(i-8) +: 8] = ($urandom_range(9) < 7) ? alpha[$urandom_range(2)] :
					8'($urandom);
		end
		write_reg(fsr_pkg::REG_SEARCH_LOW, lo);
		write_reg(fsr_pkg::REG_SEARCH_HIGH, hi);
		write_reg(fsr_pkg::REG_SEARCH_LENGTH, slen_data);
		write_reg(fsr_pkg::REG_REPLACE_LOW, {$urandom, $urandom});
		write_reg(fsr_pkg::REG_REPLACE_HIGH, {$urandom, $urandom});
		write_reg(fsr_pkg::REG_REPLACE_LENGTH, rlen_data);
	endtask

	// Random texts built from whole and broken copies of the search string, single bytes of it and random bytes
	task automatic gen_texts(int n_items);
		logic [7:0] txt [$];
		int         counted;
		int         len;
		int         slen;
		int         k;
		int         pos;
		int         r;
		bit         end_on_byte;
		counted = 0;
		slen = capped(srch_len_reg);
		while (counted < n_items) begin
			txt.delete();
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(0, 12);
			while (txt.size() < len) begin
				r = $urandom_range(9);
				if (r < 3 && slen > 0) begin
					for (k = 0; k < slen; k++)
						txt.push_back(pat_char(srch_lo, srch_hi, k));
					if ($urandom_range(2) == 0) begin
						pos = txt.size() - 1 - $urandom_range(slen - 1);
						txt[pos] = 8'($urandom);
					end
				end else if (r < 6 && slen > 0) begin
					txt.push_back(pat_char(srch_lo, srch_hi, $urandom_range(slen - 1)));
				end else begin
					txt.push_back(8'($urandom));
				end
			end
			end_on_byte = $urandom_range(1);
			for (k = 0; k < txt.size(); k++) begin
				if ($urandom_range(19) == 0)
					add_item(8'($urandom), 1'b0, 1'b0);
				add_item(txt[k], 1'b1, end_on_byte && (k == txt.size() - 1));
			end
			counted += txt.size();
			if (!end_on_byte || txt.size() == 0) begin
				add_item(8'($urandom), 1'b0, 1'b1);
				counted++;
			end
		end
	endtask

	// Run watchdog
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int slen_set [6];
		int rlen_set [6];
		int s;
		slen_set = '{31, 16, 0, 1, 7, 4};
		rlen_set = '{17, 1, 5, 16, 0, 4};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Pass-through after reset: extreme bytes, an empty item, both kinds of end
		add_item(8'h00, 1'b1, 1'b0);
		add_item(8'hFF, 1'b1, 1'b0);
		add_item(8'($urandom), 1'b0, 1'b0);
		add_item(8'h5A, 1'b1, 1'b1);
		add_item(8'($urandom), 1'b0, 1'b1);
		wait_idle();

		// Search "abc", replace with "XY"; flush of a partial match at end
		write_reg(fsr_pkg::REG_SEARCH_LOW, 64'h0000_0000_0063_6261);
		write_reg(fsr_pkg::REG_SEARCH_LENGTH, 64'd3);
		write_reg(fsr_pkg::REG_REPLACE_LOW, 64'h0000_0000_0000_5958);
		write_reg(fsr_pkg::REG_REPLACE_LENGTH, 64'd2);
		add_text("xabcab", 1'b0);
		add_item(8'h00, 1'b0, 1'b1);
		wait_idle();

		// Rewrite the search length with bytes pending: the window is dropped
		add_text("ab", 1'b0);
		wait_idle();
		write_reg(fsr_pkg::REG_SEARCH_LENGTH, 64'd3);
		add_item(8'($urandom), 1'b0, 1'b1);
		wait_idle();

		// Change the search bytes mid-text, then delete matches with an empty replacement
		add_text("a", 1'b0);
		wait_idle();
		write_reg(fsr_pkg::REG_SEARCH_LOW, 64'h0000_0000_0063_2361);
		add_text("#c", 1'b1);
		wait_idle();
		write_reg(fsr_pkg::REG_REPLACE_LENGTH, 64'd0);
		add_text("a#c", 1'b1);
		wait_idle();

		// Random texts over several settings, oversized lengths and junk upper bits among them
		for (s = 0; s < 6; s++) begin
			if (s < 2) begin
				send_idle = 24;
				recv_idle = 67;
			end else if (s < 4) begin
				send_idle = 67;
				recv_idle = 24;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (s == 5)
				set_pattern({$urandom, $urandom} & ~64'h1F | 64'(slen_set[s]), 64'(rlen_set[s]));
			else
				set_pattern(64'(slen_set[s]), 64'(rlen_set[s]));
			gen_texts(56);
			wait_idle();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
design/fsr_pkg.sv
design/fsr_front.sv
design/fsr_cmd_queue.sv
design/fsr_back.sv
design/stream_find_replace_core.sv
verif/stream_find_replace_core_tb.sv
